// ===== rtl/core/lbs_pkg.sv =====
// Shared types and constants of the bounded LIFO stack.
package lbs_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_DUMP = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_e;

	// Move command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
		logic rotate;
	} cell_op_t;

endpackage

// ===== rtl/core/lbs_if.sv =====
// Request and response channel interfaces of the bounded LIFO stack.
interface lbs_req_if import lbs_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   kind;
	word_t        push_value;

	modport source (output valid, kind, push_value, input ready);
	modport sink   (input valid, kind, push_value, output ready);
endinterface

interface lbs_rsp_if import lbs_pkg::*; ();
	logic         valid;
	logic         ready;
	word_t        word;
	logic [1:0]   status;
	logic         last;
	logic         is_empty;
	logic         is_full;

	modport source (output valid, word, status, last, is_empty, is_full, input ready);
	modport sink   (input valid, word, status, last, is_empty, is_full, output ready);
endinterface

// ===== rtl/core/bounded_lifo_stack_unit.sv =====
// Top level of the bounded LIFO stack: control, result register and cell chain.
//
// A bounded last-in first-out store of DEPTH signed 32-bit words, built as a
// chain of cells where cell 0 always holds the top entry. A push shifts the
// chain down and loads the new word into cell 0; a pop shifts it up. Push, pop
// and peek take one request each cycle while the result slot is free. A dump
// of N entries emits the head at each step while the occupied cells rotate by
// one, the head wrapping to the tail, so after N steps the store is back as
// it was; a step waits while a result is stalled, and no new request is taken
// during a dump. An empty dump gives one result. Every result carries the
// empty and full flags taken after the request. Results sit in an output
// register, so a new request is taken while an earlier result waits, as long
// as the downstream side takes it in the same cycle. No clearing pass is
// needed: reset clears control state only; entries are read only once written.
module bounded_lifo_stack_unit import lbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lbs_req_if.sink   req,
	lbs_rsp_if.source rsp
);

	cnt_t     count_q;
	cnt_t     dump_left_q;
	logic     dump_q;
	logic     out_valid_q;
	word_t    out_word_q;
	status_e  out_status_q;
	logic     out_last_q;
	logic     out_empty_q;
	logic     out_full_q;

	word_t    cell_data [DEPTH];
	cell_op_t op;

	logic     slot_free;
	logic     accept;
	logic     dump_step;
	logic     st_empty;
	logic     st_full;
	kind_e    kind;

	logic     res_emit;
	word_t    res_word;
	status_e  res_status;
	logic     res_last;
	cnt_t     count_nxt;
	logic     dump_nxt;
	cnt_t     dump_left_nxt;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = !dump_q && slot_free;
	assign accept    = req.valid && req.ready;
	assign dump_step = dump_q && slot_free;
	assign st_empty  = count_q == '0;
	assign st_full   = count_q == CNT_W'(DEPTH);
	assign kind      = kind_e'(req.kind);

	// Decode the request into a chain move and one result.
	always_comb begin
		op            = '0;
		res_emit      = 1'b0;
		res_word      = '0;
		res_status    = ST_OK;
		res_last      = 1'b1;
		count_nxt     = count_q;
		dump_nxt      = dump_q;
		dump_left_nxt = dump_left_q;
		if (dump_step) begin
			// Continue a dump: emit the head, rotate the occupied cells.
			res_emit      = 1'b1;
			res_word      = cell_data[0];
			op.rotate     = 1'b1;
			res_last      = dump_left_q == CNT_W'(1);
			dump_left_nxt = dump_left_q - CNT_W'(1);
			dump_nxt      = !res_last;
		end else if (accept) begin
			res_emit = 1'b1;
			case (kind)
				KIND_PUSH: begin
					if (st_full) begin
						res_status = ST_OVERFLOW;
					end else begin
						op.push   = 1'b1;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				KIND_POP: begin
					if (st_empty) begin
						res_status = ST_EMPTY;
					end else begin
						op.pop    = 1'b1;
						res_word  = cell_data[0];
						count_nxt = count_q - CNT_W'(1);
					end
				end
				KIND_PEEK: begin
					if (st_empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_word = cell_data[0];
					end
				end
				KIND_DUMP: begin
					if (st_empty) begin
						res_status = ST_EMPTY;
					end else begin
						// First entry goes out now; hold off requests for the rest.
						res_word      = cell_data[0];
						op.rotate     = 1'b1;
						res_last      = count_q == CNT_W'(1);
						dump_nxt      = !res_last;
						dump_left_nxt = count_q - CNT_W'(1);
					end
				end
				default: begin
					res_emit = 1'b0;
				end
			endcase
		end
	end

	// Control state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_q      <= 1'b0;
			dump_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_nxt;
			dump_q      <= dump_nxt;
			dump_left_q <= dump_left_nxt;
			if (res_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_emit) begin
			out_word_q   <= res_word;
			out_status_q <= res_status;
			out_last_q   <= res_last;
			out_empty_q  <= count_nxt == '0;
			out_full_q   <= count_nxt == CNT_W'(DEPTH);
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.word     = out_word_q;
	assign rsp.status   = out_status_q;
	assign rsp.last     = out_last_q;
	assign rsp.is_empty = out_empty_q;
	assign rsp.is_full  = out_full_q;

	// Cell chain: cell 0 is the top of the stack.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t upper;
		word_t lower;
		logic  is_tail;

		if (i == 0) begin : g_first
			assign upper = req.push_value;
		end else begin : g_mid_up
			assign upper = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign lower = cell_data[i];
		end else begin : g_mid_dn
			assign lower = cell_data[i+1];
		end
		assign is_tail = count_q == CNT_W'(i + 1);

		lbs_cell u_cell (
			.clk     (clk),
			.op      (op),
			.upper   (upper),
			.lower   (lower),
			.head    (cell_data[0]),
			.is_tail (is_tail),
			.data    (cell_data[i])
		);
	end

endmodule

// ===== rtl/core/lbs_cell.sv =====
// One storage cell of the stack chain: holds one entry, moves with its neighbors.
module lbs_cell import lbs_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  word_t    upper,
	input  word_t    lower,
	input  word_t    head,
	input  logic     is_tail,
	output word_t    data
);

	word_t data_q;

	// Push: take from the cell above. Pop: take from below.
	// Rotate: take from below, the tail cell takes the head entry.
	always_ff @(posedge clk) begin
		if (op.push) begin
			data_q <= upper;
		end else if (op.pop) begin
			data_q <= lower;
		end else if (op.rotate) begin
			data_q <= is_tail ? head : lower;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/core/lbs_checker.sv =====
// Port-level checks of the bounded LIFO stack, bound to its top level.
module lbs_checker import lbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input word_t      rsp_word,
	input logic [1:0] rsp_status,
	input logic       rsp_last,
	input logic       rsp_is_empty,
	input logic       rsp_is_full
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_status)
			&& $stable(rsp_last))
		else $error("stalled response changed");

	// The store cannot be empty and full at once.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_is_empty && rsp_is_full))
		else $error("empty and full both set");

	// Overflow only on a full store, and it ends the request.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_OVERFLOW |-> rsp_is_full && rsp_last && rsp_word == '0)
		else $error("overflow result inconsistent");

	// An empty result carries no word, ends the request and shows an empty store.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_last && rsp_word == '0)
		else $error("underflow result inconsistent");

	// Only defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_OVERFLOW
			|| rsp_status == ST_EMPTY)
		else $error("undefined status code");

endmodule

bind bounded_lifo_stack_unit lbs_checker u_lbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_word     (rsp.word),
	.rsp_status   (rsp.status),
	.rsp_last     (rsp.last),
	.rsp_is_empty (rsp.is_empty),
	.rsp_is_full  (rsp.is_full)
);
